### sv/raster_badline_sequencer_unit_defines.svh
// Assertion macros shared by the raster bad-line sequencer RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RASTER_BADLINE_SEQUENCER_UNIT_DEFINES_SVH
`define RASTER_BADLINE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define RBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBS_ASSERT_SAME(label, ante, cons, msg)
`define RBS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### sv/rbs_pkg.sv
// Types and constants of the raster bad-line sequencer.
// Used by rbs_seq and raster_badline_sequencer_unit; depends on nothing.
package rbs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CYCLES_PER_LINE  = 3'd0;
    localparam logic [2:0] CFG_LINES_PER_FRAME  = 3'd1;
    localparam logic [2:0] CFG_IRQ_COMPARE_LINE = 3'd2;
    localparam logic [2:0] CFG_FINE_Y_SCROLL    = 3'd3;
    localparam logic [2:0] CFG_DISPLAY_ENABLE   = 3'd4;
    localparam logic [2:0] CFG_LIGHTPEN_PHI1    = 3'd5;
    localparam logic [2:0] CFG_LIGHTPEN_DELAY   = 3'd6;

    // Raster line and cycle landmarks.
    localparam logic [8:0] BADLINE_START = 9'h030;
    localparam logic [8:0] BADLINE_END   = 9'h0f7;
    localparam logic [6:0] FETCH_OPEN    = 7'd11;
    localparam logic [6:0] ROW_CLEAR     = 7'd13;
    localparam logic [6:0] FETCH_CLOSE   = 7'd54;
    localparam logic [6:0] ROW_STEP      = 7'd57;

    typedef struct packed {
        logic       pen_strobe;
        logic [8:0] pen_xpos;
    } item_t;

    typedef struct packed {
        logic [6:0] cycle_index;
        logic [8:0] raster_line;
        logic       bad_line;
        logic       char_fetch_request;
        logic [2:0] row_count;
        logic       display_state;
        logic       raster_irq;
        logic       pen_irq;
        logic [7:0] pen_x;
        logic [7:0] pen_y;
    } result_t;

    typedef struct packed {
        logic [6:0] cycles_per_line;
        logic [8:0] lines_per_frame;
        logic [8:0] irq_compare_line;
        logic [2:0] fine_y_scroll;
        logic       display_enable;
        logic       lightpen_phi1;
        logic [3:0] lightpen_delay;
    } cfg_t;

endpackage

### sv/rbs_seq.sv
// Raster sequencer state and its one-tick update.
// Depends on rbs_pkg for the item, result and configuration types.
module rbs_seq
    import rbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [6:0] cycle_reg, cycle_next;
    logic [8:0] line_reg, line_next;
    logic       wrap_reg, wrap_next;
    logic       window_reg, window_next;
    logic       flag_reg, flag_next;
    logic [2:0] row_reg, row_next;
    logic       idle_reg, idle_next;
    logic       fetch_reg, fetch_next;
    logic       matched_reg, matched_next;
    logic       latched_reg, latched_next;
    logic       pen_def_reg, pen_def_next;
    logic [7:0] pen_x_reg, pen_x_next;
    logic [7:0] pen_y_reg, pen_y_next;
    logic       raster_irq;
    logic       pen_irq;

    always_comb
    begin
        cycle_next   = cycle_reg;
        line_next    = line_reg;
        wrap_next    = wrap_reg;
        window_next  = window_reg;
        flag_next    = flag_reg;
        row_next     = row_reg;
        idle_next    = idle_reg;
        fetch_next   = fetch_reg;
        matched_next = matched_reg;
        latched_next = latched_reg;
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        pen_irq      = pen_def_reg;
        pen_def_next = 1'b0;
        raster_irq   = 1'b0;

        // The frame wrap deferred from the previous tick lands first.
        if (wrap_reg)
        begin
            line_next    = '0;
            wrap_next    = 1'b0;
            latched_next = 1'b0;
            window_next  = 1'b0;
        end

        cycle_next = cycle_reg + 7'd1;
        if (cycle_next == cfg.cycles_per_line)
        begin
            cycle_next = '0;
            if (line_next == BADLINE_END)
                window_next = 1'b0;
            line_next = line_next + 9'd1;
            if (line_next == cfg.lines_per_frame)
            begin
                line_next = line_next - 9'd1;
                wrap_next = 1'b1;
            end
            else if (!window_next && line_next == BADLINE_START && cfg.display_enable)
            begin
                window_next = 1'b1;
            end
            flag_next = window_next && (cfg.fine_y_scroll == line_next[2:0]);
            if (flag_next)
                idle_next = 1'b0;
        end
        else if (cycle_next == FETCH_OPEN)
        begin
            fetch_next = 1'b1;
        end
        else if (cycle_next == ROW_CLEAR)
        begin
            if (flag_reg)
                row_next = '0;
        end
        else if (cycle_next == FETCH_CLOSE)
        begin
            fetch_next = 1'b0;
        end
        else if (cycle_next == ROW_STEP)
        begin
            if (row_reg == 3'd7)
                idle_next = 1'b1;
            if (!idle_next || flag_reg)
            begin
                row_next  = row_reg + 3'd1;
                idle_next = 1'b0;
            end
        end

        if (line_next == cfg.irq_compare_line)
        begin
            if (!matched_reg)
            begin
                raster_irq   = 1'b1;
                matched_next = 1'b1;
            end
        end
        else
        begin
            matched_next = 1'b0;
        end

        // The pen latches once per frame; a strobe on the last line only
        // uses up that chance.
        if (item.pen_strobe && !latched_next)
        begin
            latched_next = 1'b1;
            if (line_next != cfg.lines_per_frame - 9'd1)
            begin
                pen_x_next = item.pen_xpos[8:1] + {4'd0, cfg.lightpen_delay};
                if (!cfg.lightpen_phi1 && cycle_next == cfg.cycles_per_line - 7'd1)
                    pen_y_next = line_next[7:0] + 8'd1;
                else
                    pen_y_next = line_next[7:0];
                if (cfg.lightpen_phi1)
                    pen_irq = 1'b1;
                else
                    pen_def_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg   <= '0;
            line_reg    <= '0;
            wrap_reg    <= 1'b0;
            window_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            row_reg     <= '0;
            idle_reg    <= 1'b0;
            fetch_reg   <= 1'b0;
            matched_reg <= 1'b0;
            latched_reg <= 1'b0;
            pen_def_reg <= 1'b0;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
        end
        else if (step_en)
        begin
            cycle_reg   <= cycle_next;
            line_reg    <= line_next;
            wrap_reg    <= wrap_next;
            window_reg  <= window_next;
            flag_reg    <= flag_next;
            row_reg     <= row_next;
            idle_reg    <= idle_next;
            fetch_reg   <= fetch_next;
            matched_reg <= matched_next;
            latched_reg <= latched_next;
            pen_def_reg <= pen_def_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
        end
    end

    always_comb
    begin
        result.cycle_index        = cycle_next;
        result.raster_line        = line_next;
        result.bad_line           = flag_next;
        result.char_fetch_request = flag_next && fetch_next;
        result.row_count          = row_next;
        result.display_state      = !idle_next;
        result.raster_irq         = raster_irq;
        result.pen_irq            = pen_irq;
        result.pen_x              = pen_x_next;
        result.pen_y              = pen_y_next;
    end

endmodule

### sv/raster_badline_sequencer_unit.sv
// Raster bad-line sequencer: one video-chip tick per request, one result per tick.
// A request waits in the input register until it steps into the result register.
// Throughput: one request per cycle when not stalled; the input register and the
// result register let a new request in while a finished result waits downstream.
// Reset (rst_n, asynchronous, active low) clears all sequencer state, empties both
// stages and loads the configuration defaults. Depends on rbs_pkg and rbs_seq.
`include "raster_badline_sequencer_unit_defines.svh"

module raster_badline_sequencer_unit
    import rbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data
);

    // Configuration registers. Writes must happen only while the block is idle;
    // the block does not enforce it. Each is taken at once, never back-pressured.
    cfg_t    cfg_reg;

    // Input stage: holds one accepted request until the sequencer step.
    logic    in_full_reg;
    item_t   item_reg;

    // Result stage.
    logic    out_full_reg;
    result_t result_reg;

    logic    advance;
    result_t step_result;

    assign cfg_ready = 1'b1;

    // The sequencer steps when the input stage holds a request and the
    // result register is free or being emptied in this cycle.
    assign advance    = in_full_reg && (!out_full_reg || !result_stall);
    assign item_stall = in_full_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycles_per_line  <= 7'd63;
            cfg_reg.lines_per_frame  <= 9'd312;
            cfg_reg.irq_compare_line <= 9'd0;
            cfg_reg.fine_y_scroll    <= 3'd0;
            cfg_reg.display_enable   <= 1'b0;
            cfg_reg.lightpen_phi1    <= 1'b0;
            cfg_reg.lightpen_delay   <= 4'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CYCLES_PER_LINE:  cfg_reg.cycles_per_line  <= cfg_data[6:0];
                CFG_LINES_PER_FRAME:  cfg_reg.lines_per_frame  <= cfg_data[8:0];
                CFG_IRQ_COMPARE_LINE: cfg_reg.irq_compare_line <= cfg_data[8:0];
                CFG_FINE_Y_SCROLL:    cfg_reg.fine_y_scroll    <= cfg_data[2:0];
                CFG_DISPLAY_ENABLE:   cfg_reg.display_enable   <= cfg_data[0];
                CFG_LIGHTPEN_PHI1:    cfg_reg.lightpen_phi1    <= cfg_data[0];
                CFG_LIGHTPEN_DELAY:   cfg_reg.lightpen_delay   <= cfg_data[3:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake control of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_full_reg <= 1'b1;
            else if (!result_stall)
                out_full_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
        if (advance)
            result_reg <= step_result;
    end

    rbs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    assign result_valid = out_full_reg;
    assign result       = result_reg;

    `RBS_ASSERT_SAME(a_stall_needs_full, item_stall, in_full_reg, "stall while empty")
    `RBS_ASSERT_NEXT(a_step_fills_output, in_full_reg && !out_full_reg, result_valid, "step missed")
    `RBS_ASSERT_SAME(a_fetch_on_badline, result_valid && result.char_fetch_request, result.bad_line, "fetch off bad line")
    `RBS_ASSERT_SAME(a_badline_display, result_valid && result.bad_line, result.display_state, "bad line idle")

endmodule

### tb/sv/raster_badline_sequencer_unit_tb.sv
// Self-checking testbench for raster_badline_sequencer_unit: a short directed table,
// then random phases under random config; results checked by a predictor or typed rows.
// Depends on rbs_pkg and the raster_badline_sequencer_unit RTL.
module raster_badline_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbs_pkg::*;

    // Index 7 selects no register; a write to it must leave every setting alone.
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 650;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SHOWN_MISMATCHES = 10;

    // One row of the directed table: either a register write or a request,
    // optionally with the result typed in by hand.
    typedef struct packed {
        logic       is_write;
        logic [2:0] index;
        logic [8:0] data;
        item_t      stim;
        logic       typed;
        result_t    want;
    } plan_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;

    raster_badline_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: the raster sequencer as the testbench sees it.
    // Everything clears on reset; the registers come up at their defaults.
    // ------------------------------------------------------------------
    cfg_t regs = '{
        cycles_per_line:  7'd63,
        lines_per_frame:  9'd312,
        irq_compare_line: 9'd0,
        fine_y_scroll:    3'd0,
        display_enable:   1'b0,
        lightpen_phi1:    1'b0,
        lightpen_delay:   4'd0
    };
    logic [6:0] cyc          = '0;
    logic [8:0] line         = '0;
    logic       wrap_due     = 1'b0;
    logic       window_open  = 1'b0;
    logic       bad_now      = 1'b0;
    logic [2:0] rows         = '0;
    logic       idle_mode    = 1'b0;
    logic       fetch_open   = 1'b0;
    logic       irq_seen     = 1'b0;
    logic       pen_taken    = 1'b0;
    logic       pen_irq_next = 1'b0;
    logic [7:0] pen_x_q      = '0;
    logic [7:0] pen_y_q      = '0;

    // Snapshots of the raster state that the block still owes us, oldest first.
    result_t expected_snapshots[$];

    int  mismatch_count = 0;
    int  clock_ticks    = 0;
    int  stall_left     = 0;
    // When set, neither side inserts gaps or stalls, so back-to-back traffic is covered.
    logic calm = 1'b0;
    result_t oldest;
    string   bad_fields;

    // The nine-bit registers take the whole write data and the narrow ones
    // keep their low bits.
    function automatic void load_register(logic [2:0] idx, logic [8:0] data);
        case (idx)
            CFG_CYCLES_PER_LINE:  regs.cycles_per_line  = data[6:0];
            CFG_LINES_PER_FRAME:  regs.lines_per_frame  = data;
            CFG_IRQ_COMPARE_LINE: regs.irq_compare_line = data;
            CFG_FINE_Y_SCROLL:    regs.fine_y_scroll    = data[2:0];
            CFG_DISPLAY_ENABLE:   regs.display_enable   = data[0];
            CFG_LIGHTPEN_PHI1:    regs.lightpen_phi1    = data[0];
            CFG_LIGHTPEN_DELAY:   regs.lightpen_delay   = data[3:0];
            default: ;
        endcase
    endfunction

    // Advances the raster sequencer by one chip tick and returns what the
    // block should show for it.
    function automatic result_t step_raster(item_t stim);
        result_t    snap;
        logic       raster_irq_now;
        logic       pen_irq_now;
        logic [8:0] last_line;
        raster_irq_now = 1'b0;
        pen_irq_now    = pen_irq_next;
        pen_irq_next   = 1'b0;

        // The last line of a frame was held for one extra tick; now wrap to line 0.
        if (wrap_due)
        begin
            line        = '0;
            wrap_due    = 1'b0;
            pen_taken   = 1'b0;
            window_open = 1'b0;
        end

        // The cycle counter is 7 bits wide, so a line length below the current
        // cycle only ends the line after the counter wraps round.
        cyc = cyc + 7'd1;
        if (cyc == regs.cycles_per_line)
        begin
            cyc = '0;
            if (line == BADLINE_END)
                window_open = 1'b0;
            line = line + 9'd1;
            if (line == regs.lines_per_frame)
            begin
                // Stay on the last line one more tick before the wrap.
                line     = line - 9'd1;
                wrap_due = 1'b1;
            end
            else if (!window_open && line == BADLINE_START && regs.display_enable)
            begin
                window_open = 1'b1;
            end
            bad_now = window_open && (regs.fine_y_scroll == line[2:0]);
            if (bad_now)
                idle_mode = 1'b0;
        end
        else if (cyc == FETCH_OPEN)
        begin
            fetch_open = 1'b1;
        end
        else if (cyc == ROW_CLEAR)
        begin
            if (bad_now)
                rows = '0;
        end
        else if (cyc == FETCH_CLOSE)
        begin
            fetch_open = 1'b0;
        end
        else if (cyc == ROW_STEP)
        begin
            if (rows == 3'd7)
                idle_mode = 1'b1;
            if (!idle_mode || bad_now)
            begin
                rows      = rows + 3'd1;
                idle_mode = 1'b0;
            end
        end

        // Raster interrupt fires once on entering the compare line.
        if (line == regs.irq_compare_line)
        begin
            if (!irq_seen)
            begin
                raster_irq_now = 1'b1;
                irq_seen       = 1'b1;
            end
        end
        else
        begin
            irq_seen = 1'b0;
        end

        // The pen latches once per frame. On the frame's last line the strobe
        // only uses up the latch; coordinates and interrupt stay as they are.
        if (stim.pen_strobe && !pen_taken)
        begin
            pen_taken = 1'b1;
            last_line = regs.lines_per_frame - 9'd1;
            if (line != last_line)
            begin
                pen_x_q = stim.pen_xpos[8:1] + {4'd0, regs.lightpen_delay};
                if (!regs.lightpen_phi1 && cyc == regs.cycles_per_line - 7'd1)
                    pen_y_q = line[7:0] + 8'd1;
                else
                    pen_y_q = line[7:0];
                if (regs.lightpen_phi1)
                    pen_irq_now = 1'b1;
                else
                    pen_irq_next = 1'b1;
            end
        end

        snap.cycle_index        = cyc;
        snap.raster_line        = line;
        snap.bad_line           = bad_now;
        snap.char_fetch_request = bad_now && fetch_open;
        snap.row_count          = rows;
        snap.display_state      = !idle_mode;
        snap.raster_irq         = raster_irq_now;
        snap.pen_irq            = pen_irq_now;
        snap.pen_x              = pen_x_q;
        snap.pen_y              = pen_y_q;
        return snap;
    endfunction

    function automatic string field_diff(result_t want, result_t got);
        string s;
        s = "";
        if (got.cycle_index !== want.cycle_index)               s = {s, " cycle_index"};
        if (got.raster_line !== want.raster_line)               s = {s, " raster_line"};
        if (got.bad_line !== want.bad_line)                     s = {s, " bad_line"};
        if (got.char_fetch_request !== want.char_fetch_request) s = {s, " char_fetch_request"};
        if (got.row_count !== want.row_count)                   s = {s, " row_count"};
        if (got.display_state !== want.display_state)           s = {s, " display_state"};
        if (got.raster_irq !== want.raster_irq)                 s = {s, " raster_irq"};
        if (got.pen_irq !== want.pen_irq)                       s = {s, " pen_irq"};
        if (got.pen_x !== want.pen_x)                           s = {s, " pen_x"};
        if (got.pen_y !== want.pen_y)                           s = {s, " pen_y"};
        return s;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endfunction

    function automatic plan_row_t poke(logic [2:0] idx, logic [8:0] data);
        plan_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.index    = idx;
        r.data     = data;
        return r;
    endfunction

    function automatic plan_row_t tick(logic strobe, logic [8:0] xpos);
        plan_row_t r;
        r                 = '0;
        r.stim.pen_strobe = strobe;
        r.stim.pen_xpos   = xpos;
        return r;
    endfunction

    function automatic plan_row_t seen(logic strobe, logic [8:0] xpos, result_t want);
        plan_row_t r;
        r       = tick(strobe, xpos);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Inputs change on the falling edge; acceptance is seen
    // at the rising edge where valid is high and stall is low.
    // ------------------------------------------------------------------
    task automatic send_request(item_t stim, logic typed, result_t want);
        int      gap;
        result_t snap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid = 1'b1;
        item       = stim;
        do
            @(posedge clk);
        while (item_stall);
        // The predictor always runs so its state stays in step; a hand-typed
        // row replaces its answer in the queue.
        snap = step_raster(stim);
        expected_snapshots.push_back(typed ? want : snap);
    endtask

    // Stops sending and waits until every owed result has come back, so the
    // block is idle before the next register write.
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_snapshots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [8:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        load_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: draws a stall length after every accepted result and
    // compares each result against the oldest owed snapshot.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_snapshots.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing owed: %p", result));
            end
            else
            begin
                oldest     = expected_snapshots.pop_front();
                bad_fields = field_diff(oldest, result);
                if (bad_fields != "")
                    flag_mismatch($sformatf("wrong%s: expected %p, got %p",
                                            bad_fields, oldest, result));
            end
            stall_left = calm ? 0 : $urandom_range(0, 9);
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
        end
    end

    always @(negedge clk)
        result_stall = (stall_left != 0);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        clock_ticks++;
        if (clock_ticks > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    plan_row_t plan [0:27];

    initial
    begin
        item_t      stim;
        int         sent;
        int         phase;
        int         span;
        logic [2:0] idx;

        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        result_stall = 1'b0;

        // The first two rows come straight out of reset: line 0 matches the
        // default compare line at once, and the pen latches x = 511 >> 1 with
        // its interrupt held back one tick in phi2 mode. The second strobe is
        // ignored because the pen is already taken this frame.
        // After that the frame shrinks to three short lines, so the deferred
        // wrap, the pen on the last line and the phi1 latch all come up in
        // the table. Index 7 is written to show it is ignored.
        plan = '{
            seen(1'b1, 9'd511, '{cycle_index: 7'd1, raster_line: 9'd0, bad_line: 1'b0,
                                 char_fetch_request: 1'b0, row_count: 3'd0,
                                 display_state: 1'b1, raster_irq: 1'b1, pen_irq: 1'b0,
                                 pen_x: 8'd255, pen_y: 8'd0}),
            seen(1'b1, 9'd0,   '{cycle_index: 7'd2, raster_line: 9'd0, bad_line: 1'b0,
                                 char_fetch_request: 1'b0, row_count: 3'd0,
                                 display_state: 1'b1, raster_irq: 1'b0, pen_irq: 1'b1,
                                 pen_x: 8'd255, pen_y: 8'd0}),
            poke(CFG_CYCLES_PER_LINE, 9'd3),
            poke(CFG_LINES_PER_FRAME, 9'd3),
            poke(CFG_IRQ_COMPARE_LINE, 9'd2),
            poke(CFG_LIGHTPEN_DELAY, 9'd15),
            poke(CFG_FINE_Y_SCROLL, 9'd7),
            poke(CFG_DISPLAY_ENABLE, 9'd1),
            poke(CFG_UNUSED, 9'h1ff),
            tick(1'b0, 9'd0),
            tick(1'b0, 9'd1),
            tick(1'b0, 9'd2),
            tick(1'b0, 9'd3),
            tick(1'b1, 9'd510),
            tick(1'b0, 9'd4),
            tick(1'b0, 9'd5),
            tick(1'b0, 9'd6),
            tick(1'b0, 9'd7),
            tick(1'b0, 9'd8),
            tick(1'b0, 9'd9),
            tick(1'b0, 9'd10),
            tick(1'b1, 9'd511),
            tick(1'b0, 9'd11),
            poke(CFG_LIGHTPEN_PHI1, 9'd1),
            tick(1'b0, 9'd12),
            tick(1'b0, 9'd13),
            tick(1'b1, 9'h155),
            tick(1'b0, 9'h0aa)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                settle();
                write_register(plan[i].index, plan[i].data);
            end
            else
            begin
                send_request(plan[i].stim, plan[i].typed, plan[i].want);
            end
        end

        // Random phases rotate through three shapes:
        //  - sweep: one-cycle lines race the raster through the bad-line
        //    window and the frame wrap, so every tick is a line end;
        //  - scan: full-length lines that pass the fetch window, the row
        //    clear and the row step, so the row counter and idle mode move;
        //  - wild: every register takes arbitrary write data, including
        //    line lengths shorter than the current cycle.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            case (phase % 3)
                0:
                begin
                    write_register(CFG_CYCLES_PER_LINE, 9'd1);
                    write_register(CFG_LINES_PER_FRAME,
                                   ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                               : 9'($urandom_range(49, 511)));
                    write_register(CFG_DISPLAY_ENABLE, 9'($urandom_range(0, 3) != 0));
                    span = $urandom_range(60, 160);
                end
                1:
                begin
                    write_register(CFG_CYCLES_PER_LINE, 9'($urandom_range(58, 65)));
                    span = $urandom_range(120, 300);
                end
                default:
                begin
                    for (idx = CFG_CYCLES_PER_LINE; idx <= CFG_LIGHTPEN_DELAY; idx++)
                        write_register(idx, 9'($urandom_range(0, 511)));
                    span = $urandom_range(20, 60);
                end
            endcase
            if (phase % 3 != 2)
            begin
                // Put the compare line just ahead of the raster half the time
                // so the raster interrupt actually fires.
                write_register(CFG_IRQ_COMPARE_LINE,
                               $urandom_range(0, 1) ? line + 9'($urandom_range(1, 8))
                                                    : 9'($urandom_range(0, 511)));
                write_register(CFG_FINE_Y_SCROLL, 9'($urandom_range(0, 7)));
                write_register(CFG_LIGHTPEN_PHI1, 9'($urandom_range(0, 1)));
                write_register(CFG_LIGHTPEN_DELAY, 9'($urandom_range(0, 15)));
            end
            if (span > RANDOM_REQUESTS - sent)
                span = RANDOM_REQUESTS - sent;
            repeat (span)
            begin
                stim.pen_strobe = ($urandom_range(0, 3) == 0);
                stim.pen_xpos   = 9'($urandom_range(0, 511));
                send_request(stim, 1'b0, '0);
            end
            sent  += span;
            phase++;
        end

        settle();
        // Keep clocking after settling so a stray extra result would still be caught.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### raster_badline_sequencer_unit.f
+incdir+sv
sv/rbs_pkg.sv
sv/rbs_seq.sv
sv/raster_badline_sequencer_unit.sv
tb/sv/raster_badline_sequencer_unit_tb.sv
